### rtl/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg
// shared types and constants of the frame receiver with byte destuffing
// ----------------------------------------------------------------------------
package ifd_pkg;

    // framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_MASK  = 8'h20;

    // default payload length limit
    localparam int MAX_FRAME_DEF = 256;

    // configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL = 2'd1;
    localparam logic [7:0] ADDRESS_RST = 8'h03;
    localparam logic [7:0] CONTROL_RST = 8'h03;

    // receiver phase
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // configured header values
    typedef struct packed {
        logic [7:0] address;
        logic [7:0] control;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       frame_end;
        logic       frame_good;
    } res_t;

endpackage

### rtl/iframe_deframer_destuff_bcc_core.sv
// ----------------------------------------------------------------------------
// iframe_deframer_destuff_bcc_core
// frame receiver with flag hunt, header check, byte destuffing and bcc2 check
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and returns exactly one result per
// byte. Bytes go into an input register; the framing logic works on that
// register combinationally and writes the output register, so a byte is
// accepted every cycle when the output side does not stall; a result
// waits in the output register until taken. The block hunts for flag
// 0x7E, then checks address, control and their XOR; in the data phase
// 0x7D escapes the next byte (XOR 0x20). One destuffed byte is always
// held back, so payload comes out one byte late and the last byte before
// the closing flag is taken as BCC2. A closing flag gives frame_end, with
// frame_good when the XOR of all data bytes is zero, the frame holds at
// least BCC2, no escape dangles and the payload is at most MAX_FRAME bytes.
// After a closing flag the receiver hunts for a fresh opening flag. The
// expected address and control are written over the config channel (index
// 0 and 1, other indexes ignored) by the user only while the block is idle,
// which the block does not enforce; cfg_ready is always high.
// ----------------------------------------------------------------------------
module iframe_deframer_destuff_bcc_core #(
    parameter int MAX_FRAME = ifd_pkg::MAX_FRAME_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // byte input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       rx_byte,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             data_valid,
    output logic [7:0]                       data_byte,
    output logic                             frame_end,
    output logic                             frame_good,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ifd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);

    ifd_pkg::cfg_t cfg;
    ifd_pkg::res_t res;
    ifd_pkg::res_t res_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_take;
    logic       step;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    ifd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the held byte moves on when the output register is free or draining
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    // input register frees up in the same cycle it moves on
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    ifd_frame_fsm #(
        .MAX_FRAME (MAX_FRAME)
    ) u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= rx_byte;
        if (step)
            res_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign data_valid = res_reg.data_valid;
    assign data_byte  = res_reg.data_byte;
    assign frame_end  = res_reg.frame_end;
    assign frame_good = res_reg.frame_good;

endmodule

### rtl/ifd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ifd_cfg_regs
// expected address and control registers, written over the config channel
// ----------------------------------------------------------------------------
module ifd_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [ifd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data,
    output ifd_pkg::cfg_t                      cfg
);

    logic [7:0] address_reg;
    logic [7:0] control_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= ifd_pkg::ADDRESS_RST;
            control_reg <= ifd_pkg::CONTROL_RST;
        end
        else if (cfg_valid)
        begin
            // unknown indexes are dropped
            case (cfg_index)
                ifd_pkg::REG_ADDRESS: address_reg <= cfg_data;
                ifd_pkg::REG_CONTROL: control_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.address = address_reg;
    assign cfg.control = control_reg;

endmodule

### rtl/ifd_frame_fsm.sv
// ----------------------------------------------------------------------------
// ifd_frame_fsm
// header hunt, destuffing, held byte, block check and length count
// ----------------------------------------------------------------------------
module ifd_frame_fsm #(
    parameter int MAX_FRAME = ifd_pkg::MAX_FRAME_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     byte_in,
    input  ifd_pkg::cfg_t  cfg,
    output ifd_pkg::res_t  res
);

    // count saturates at MAX_FRAME + 1
    localparam int CNT_W = $clog2(MAX_FRAME + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

    ifd_pkg::phase_t  phase_reg, phase_next;
    logic             esc_reg, esc_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [7:0]       parity_reg, parity_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [7:0] destuffed;
    logic       is_flag;
    logic       is_esc;

    assign is_flag   = (byte_in == ifd_pkg::FLAG_BYTE);
    assign is_esc    = (byte_in == ifd_pkg::ESC_BYTE);
    assign destuffed = esc_reg ? (byte_in ^ ifd_pkg::ESC_MASK) : byte_in;

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        parity_next     = parity_reg;
        cnt_next        = cnt_reg;
        case (phase_reg)
            ifd_pkg::PH_FLAG:
            begin
                if (byte_in == cfg.address)
                    phase_next = ifd_pkg::PH_ADDR;
                else if (is_flag)
                    phase_next = ifd_pkg::PH_FLAG;
                else
                    phase_next = ifd_pkg::PH_HUNT;
            end
            ifd_pkg::PH_ADDR:
            begin
                if (byte_in == cfg.control)
                    phase_next = ifd_pkg::PH_CTRL;
                else if (is_flag)
                    phase_next = ifd_pkg::PH_FLAG;
                else
                    phase_next = ifd_pkg::PH_HUNT;
            end
            ifd_pkg::PH_CTRL:
            begin
                if (byte_in == (cfg.address ^ cfg.control))
                begin
                    phase_next      = ifd_pkg::PH_DATA;
                    esc_next        = 1'b0;
                    held_next       = 8'h00;
                    held_valid_next = 1'b0;
                    parity_next     = 8'h00;
                    cnt_next        = '0;
                end
                else if (is_flag)
                    phase_next = ifd_pkg::PH_FLAG;
                else
                    phase_next = ifd_pkg::PH_HUNT;
            end
            ifd_pkg::PH_DATA:
            begin
                if (is_esc)
                    esc_next = 1'b1;
                else if (is_flag)
                begin
                    phase_next      = ifd_pkg::PH_HUNT;
                    esc_next        = 1'b0;
                    held_next       = 8'h00;
                    held_valid_next = 1'b0;
                    parity_next     = 8'h00;
                    cnt_next        = '0;
                end
                else
                begin
                    esc_next        = 1'b0;
                    held_next       = destuffed;
                    held_valid_next = 1'b1;
                    parity_next     = parity_reg ^ destuffed;
                    if (held_valid_reg && (cnt_reg <= CNT_MAX))
                        cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                if (is_flag)
                    phase_next = ifd_pkg::PH_FLAG;
                else
                    phase_next = ifd_pkg::PH_HUNT;
            end
        endcase
    end

    // result
    always_comb
    begin
        res = '0;
        case (phase_reg)
            ifd_pkg::PH_DATA:
            begin
                if (is_flag)
                begin
                    res.frame_end  = 1'b1;
                    res.frame_good = held_valid_reg && (parity_reg == 8'h00) &&
                                     !esc_reg && (cnt_reg <= CNT_MAX);
                end
                else if (!is_esc && held_valid_reg)
                begin
                    res.data_valid = 1'b1;
                    res.data_byte  = held_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ifd_pkg::PH_HUNT;
            esc_reg        <= 1'b0;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            parity_reg     <= 8'h00;
            cnt_reg        <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            parity_reg     <= parity_next;
            cnt_reg        <= cnt_next;
        end
    end

endmodule

### rtl/ifd_checker.sv
// ----------------------------------------------------------------------------
// ifd_checker
// port level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module ifd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             data_valid,
    input  logic [7:0]                       data_byte,
    input  logic                             frame_end,
    input  logic                             frame_good
);

    // good frame only reported with a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_good |-> frame_end)
        else $error("frame_good without frame_end");

    // payload byte and frame end never in the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(data_valid && frame_end))
        else $error("data byte and frame end together");

    // no payload means a zero data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> data_byte == 8'h00)
        else $error("data_byte not zero without data_valid");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_valid) &&
            $stable(data_byte) && $stable(frame_end) && $stable(frame_good))
        else $error("stalled result changed");

endmodule

bind iframe_deframer_destuff_bcc_core ifd_checker u_ifd_checker (.*);
